// ===== rtl/core/wncc_pkg.sv =====
package wncc_pkg;

   localparam int MAX_DIM = 4096;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int DIM_W = 13;
   localparam int POS_W = 12;
   localparam int WGT_W = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int PROD_W = 100;
   localparam int MUL_OP_W = 64;
   localparam int ROOT_W = 50;
   localparam int QUO_W = 15;

   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT_X      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT_Y      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_USE_WEIGHTS  = 3'd4;

   localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1 << WEIGHT_FRAC_BITS);
   localparam logic [15:0] SCORE_NEG_ONE = 16'h8000;
   localparam logic [15:0] SCORE_POS_MAX = 16'h7FFF;

   typedef struct packed {
      logic [7:0]       a;
      logic [7:0]       b;
      logic [WGT_W-1:0] w;
      logic             ovl;
      logic             last;
   } item_type;

   typedef struct packed {
      logic [40:0] w;
      logic [48:0] a;
      logic [48:0] b;
      logic [56:0] aa;
      logic [56:0] bb;
      logic [56:0] ab;
   } sums_type;

endpackage

// ===== rtl/core/weighted_ncc_overlap_score.sv =====
// channel | dir | tdata (low bit up)                          | tuser / tlast
// req     | in  | ref_pixel[7:0] test_pixel[15:8] weight[32:16] | tlast = frame_end
// rsp     | out | score[15:0]                                  | tuser = score_valid
// csr     | in  | csr_addr index, csr_wdata value              | -
// Pixel beats are taken one per cycle while the 4-deep queue has room; accumulation is 2 stages.
// The frame-end score uses the shared 1-bit-per-cycle multiplier (7 products of 64 bits),
// two 50-step square roots and a 15-step divide, skipped for saturated or invalid scores.
// While the score runs, req_tready drops once the queue fills.
// Reset is synchronous; it clears counters, sums and control state and sets the CSRs to their reset values.
module weighted_ncc_overlap_score (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,  // ref_pixel, test_pixel, pixel_weight
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // score
   output logic                            rsp_tuser,  // score_valid
   input  logic                            csr_we,
   input  logic [wncc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wncc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wncc_pkg::item_type in_item, q_item;
   wncc_pkg::sums_type sums;
   logic full, not_empty, pop, take, start, done;

   assign req_tready = !full;
   assign take = req_tvalid && !full;

   wncc_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .beat_take(take),
      .ref_pixel(req_tdata[7:0]), .test_pixel(req_tdata[15:8]),
      .pixel_weight(req_tdata[32:16]), .frame_end(req_tlast),
      .item(in_item)
   );

   wncc_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(take), .push_item(in_item), .full(full),
      .pop(pop), .not_empty(not_empty), .pop_item(q_item)
   );

   wncc_back u_back (
      .clock(clock), .reset(reset),
      .item_avail(not_empty), .item(q_item), .pop(pop),
      .score_done(done), .start(start), .sums_out(sums)
   );

   wncc_score u_score (
      .clock(clock), .reset(reset),
      .start(start), .sums(sums), .done(done),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule

// ===== rtl/core/wncc_front.sv =====
module wncc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [wncc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [wncc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                beat_take,
   input  logic [7:0]                          ref_pixel,
   input  logic [7:0]                          test_pixel,
   input  logic [wncc_pkg::WGT_W-1:0]          pixel_weight,
   input  logic                                frame_end,
   output wncc_pkg::item_type                  item
);

   logic [12:0] width_ff, height_ff, shift_x_ff, shift_y_ff;
   logic        use_w_ff;
   logic [wncc_pkg::POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [12:0] wd, ht;
   logic signed [14:0] wd_s, ht_s, dx_s, dy_s, x0, x1, y0, y1, x_s, y_s;
   logic [12:0] col_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 13'd1;
         height_ff  <= 13'd1;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         use_w_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            wncc_pkg::REG_IMAGE_WIDTH:  width_ff   <= csr_wdata;
            wncc_pkg::REG_IMAGE_HEIGHT: height_ff  <= csr_wdata;
            wncc_pkg::REG_SHIFT_X:      shift_x_ff <= csr_wdata;
            wncc_pkg::REG_SHIFT_Y:      shift_y_ff <= csr_wdata;
            wncc_pkg::REG_USE_WEIGHTS:  use_w_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      wd = (width_ff == 13'd0) ? 13'd1 :
           (width_ff > 13'(wncc_pkg::MAX_DIM)) ? 13'(wncc_pkg::MAX_DIM) : width_ff;
      ht = (height_ff == 13'd0) ? 13'd1 :
           (height_ff > 13'(wncc_pkg::MAX_DIM)) ? 13'(wncc_pkg::MAX_DIM) : height_ff;
      wd_s = $signed({2'b00, wd});
      ht_s = $signed({2'b00, ht});
      dx_s = $signed({{2{shift_x_ff[12]}}, shift_x_ff});
      dy_s = $signed({{2{shift_y_ff[12]}}, shift_y_ff});
      x0 = dx_s[14] ? 15'sd0 : dx_s;
      x1 = dx_s[14] ? wd_s + dx_s : wd_s;
      y0 = dy_s[14] ? 15'sd0 : dy_s;
      y1 = dy_s[14] ? ht_s + dy_s : ht_s;
      x_s = $signed({3'b000, col_ff});
      y_s = $signed({3'b000, row_ff});
      col_inc = {1'b0, col_ff} + 13'd1;

      item.a    = ref_pixel;
      item.b    = test_pixel;
      item.w    = (!use_w_ff || pixel_weight > wncc_pkg::WEIGHT_ONE) ?
                  wncc_pkg::WEIGHT_ONE : pixel_weight;
      item.ovl  = (x_s >= x0) && (x_s < x1) && (y_s >= y0) && (y_s < y1);
      item.last = frame_end;

      col_in = col_ff;
      row_in = row_ff;
      if (beat_take) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= wd) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_inc[wncc_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/core/wncc_fifo.sv =====
module wncc_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wncc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output wncc_pkg::item_type pop_item
);

   wncc_pkg::item_type mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] count_ff;

   assign full      = (count_ff == 3'd4);
   assign not_empty = (count_ff != 3'd0);
   assign pop_item  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
   end

endmodule

// ===== rtl/core/wncc_back.sv =====
module wncc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_avail,
   input  wncc_pkg::item_type item,
   output logic               pop,
   input  logic               score_done,
   output logic               start,
   output wncc_pkg::sums_type sums_out
);

   logic busy_ff;
   logic v1_ff, ovl1_ff, last1_ff;
   logic [7:0] a1_ff, b1_ff;
   logic [wncc_pkg::WGT_W-1:0] w1_ff;
   logic [24:0] wa1_ff, wb1_ff;
   wncc_pkg::sums_type acc_ff, acc_in;
   logic [32:0] aa_inc, bb_inc, ab_inc;

   assign pop = item_avail && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         v1_ff   <= 1'b0;
      end else begin
         v1_ff <= pop;
         if (pop && item.last) busy_ff <= 1'b1;
         else if (score_done)  busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ovl1_ff  <= item.ovl;
      last1_ff <= item.last;
      a1_ff    <= item.a;
      b1_ff    <= item.b;
      w1_ff    <= item.w;
      wa1_ff   <= item.w * item.a;
      wb1_ff   <= item.w * item.b;
   end

   always_comb begin
      aa_inc = wa1_ff * a1_ff;
      bb_inc = wb1_ff * b1_ff;
      ab_inc = wa1_ff * b1_ff;
      sums_out = acc_ff;
      if (v1_ff && ovl1_ff) begin
         sums_out.w  = acc_ff.w  + 41'(w1_ff);
         sums_out.a  = acc_ff.a  + 49'(wa1_ff);
         sums_out.b  = acc_ff.b  + 49'(wb1_ff);
         sums_out.aa = acc_ff.aa + 57'(aa_inc);
         sums_out.bb = acc_ff.bb + 57'(bb_inc);
         sums_out.ab = acc_ff.ab + 57'(ab_inc);
      end
      start  = v1_ff && last1_ff;
      acc_in = start ? '0 : sums_out;
   end

   always_ff @(posedge clock) begin
      if (reset) acc_ff <= '0;
      else       acc_ff <= acc_in;
   end

endmodule

// ===== rtl/core/wncc_score.sv =====
module wncc_score (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  wncc_pkg::sums_type sums,
   output logic               done,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,
   output logic               rsp_tuser
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int PW = wncc_pkg::PROD_W;
   localparam int MW = wncc_pkg::MUL_OP_W;

   logic [2:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [6:0] cnt_ff, cnt_in;
   wncc_pkg::sums_type s_ff, s_in;
   logic [MW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [PW-1:0] p_ff, p_in, t_ff, t_in, va_ff, va_in, vb_ff, vb_in;
   logic [PW-1:0] op_ff, op_in, bit_ff, bit_in, res_ff, res_in;
   logic [PW-1:0] den_ff, den_in, mag_ff, mag_in, sq_sum, p_next;
   logic [wncc_pkg::ROOT_W-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [PW:0] rem_ff, rem_in, rem_sh;
   logic [wncc_pkg::QUO_W-1:0] q_ff, q_in;
   logic neg_ff, neg_in;
   logic [15:0] sc_ff, sc_in, out_score_ff, out_score_in;
   logic ok_ff, ok_in, out_ok_ff, out_ok_in, out_v_ff, out_v_in;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_score_ff;
   assign rsp_tuser  = out_ok_ff;

   always_comb begin
      state_in = state_ff; step_in = step_ff; cnt_in = cnt_ff; s_in = s_ff;
      mx_in = mx_ff; my_in = my_ff; p_in = p_ff; t_in = t_ff;
      va_in = va_ff; vb_in = vb_ff; op_in = op_ff; bit_in = bit_ff; res_in = res_ff;
      den_in = den_ff; mag_in = mag_ff; sa_in = sa_ff; sb_in = sb_ff;
      rem_in = rem_ff; q_in = q_ff; neg_in = neg_ff; sc_in = sc_ff; ok_in = ok_ff;
      out_score_in = out_score_ff; out_ok_in = out_ok_ff;
      out_v_in = out_v_ff && !rsp_tready;
      done = 1'b0;
      p_next = {p_ff[PW-2:0], 1'b0} + (my_ff[MW-1] ? PW'(mx_ff) : '0);
      sq_sum = res_ff + bit_ff;
      rem_sh = {rem_ff[PW-1:0], 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               s_in = sums;
               step_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            p_in = '0;
            cnt_in = 7'(MW - 1);
            state_in = ST_MUL;
            case (step_ff)
               4'd0: begin mx_in = MW'(s_ff.w); my_in = MW'(s_ff.aa); end
               4'd1: begin mx_in = MW'(s_ff.a); my_in = MW'(s_ff.a); end
               4'd2: begin mx_in = MW'(s_ff.w); my_in = MW'(s_ff.bb); end
               4'd3: begin mx_in = MW'(s_ff.b); my_in = MW'(s_ff.b); end
               4'd4, 4'd5: begin
                  op_in = (step_ff == 4'd4) ? va_ff : vb_ff;
                  bit_in = PW'(1) << (2 * (wncc_pkg::ROOT_W - 1));
                  res_in = '0;
                  cnt_in = 7'(wncc_pkg::ROOT_W - 1);
                  state_in = ST_SQRT;
               end
               4'd6: begin mx_in = MW'(sa_ff); my_in = MW'(sb_ff); end
               4'd7: begin mx_in = MW'(s_ff.w); my_in = MW'(s_ff.ab); end
               4'd8: begin mx_in = MW'(s_ff.a); my_in = MW'(s_ff.b); end
               default: begin
                  if (mag_ff >= den_ff) begin
                     sc_in = neg_ff ? wncc_pkg::SCORE_NEG_ONE : wncc_pkg::SCORE_POS_MAX;
                     ok_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     rem_in = {1'b0, mag_ff};
                     q_in = '0;
                     cnt_in = 7'(wncc_pkg::QUO_W - 1);
                     state_in = ST_DIV;
                  end
               end
            endcase
         end
         ST_MUL: begin
            p_in = p_next;
            my_in = {my_ff[MW-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               step_in = step_ff + 1'b1;
               state_in = ST_LOAD;
               case (step_ff)
                  4'd0, 4'd2, 4'd7: t_in = p_next;
                  4'd1: va_in = t_ff - p_next;
                  4'd3: begin
                     vb_in = t_ff - p_next;
                     if (s_ff.w == '0 || va_ff == '0 || t_ff == p_next) begin
                        sc_in = wncc_pkg::SCORE_NEG_ONE;
                        ok_in = 1'b0;
                        state_in = ST_DONE;
                     end
                  end
                  4'd6: den_in = p_next;
                  default: begin
                     neg_in = p_next > t_ff;
                     mag_in = (p_next > t_ff) ? p_next - t_ff : t_ff - p_next;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            if (op_ff >= sq_sum) begin
               op_in = op_ff - sq_sum;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (step_ff == 4'd4) sa_in = res_in[wncc_pkg::ROOT_W-1:0];
               else                 sb_in = res_in[wncc_pkg::ROOT_W-1:0];
               step_in = step_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               q_in = {q_ff[wncc_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in = {q_ff[wncc_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               sc_in = neg_ff ? 16'(-{1'b0, q_in}) : {1'b0, q_in};
               ok_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1;
               out_score_in = sc_ff;
               out_ok_in = ok_ff;
               done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in; cnt_ff <= cnt_in; s_ff <= s_in;
      mx_ff <= mx_in; my_ff <= my_in; p_ff <= p_in; t_ff <= t_in;
      va_ff <= va_in; vb_ff <= vb_in; op_ff <= op_in; bit_ff <= bit_in; res_ff <= res_in;
      den_ff <= den_in; mag_ff <= mag_in; sa_ff <= sa_in; sb_ff <= sb_in;
      rem_ff <= rem_in; q_ff <= q_in; neg_ff <= neg_in; sc_ff <= sc_in; ok_ff <= ok_in;
      out_score_ff <= out_score_in; out_ok_ff <= out_ok_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE) else $error("frame start while score unit busy");
   a_invalid_code: assert property (@(posedge clock) disable iff (reset)
      (done && !ok_ff) |-> sc_ff == wncc_pkg::SCORE_NEG_ONE)
      else $error("invalid score not minus one");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> state_ff == ST_DIV || state_ff == ST_DONE)
      else $error("divide left early");
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result not presented");

endmodule
